### sv/mmpd_pkg.sv
// Shared constants, codes and payload types for the min/max pixel decimator.
// No dependencies; every other file of the block imports this package.
package mmpd_pkg;

   localparam int TIME_BITS   = 32;
   localparam int SAMPLE_BITS = 16;
   localparam int MAX_PIXELS  = 4096;

   // Register field widths.
   localparam int SHIFT_BITS = 5;
   localparam int PIX_BITS   = 13;

   localparam logic [PIX_BITS-1:0] MAX_PIX_CODE     = PIX_BITS'(MAX_PIXELS);
   localparam logic [PIX_BITS-1:0] PIX_COUNT_RESET  = PIX_BITS'(1024);

   // Configuration port.
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 4;
   localparam logic [1:0] REG_WINDOW_START = 2'd0;
   localparam logic [1:0] REG_PIXEL_SHIFT  = 2'd1;
   localparam logic [1:0] REG_PIXEL_COUNT  = 2'd2;

   // Points made by one sample, in output order.
   localparam int NUM_SLOTS = 4;
   localparam int SLOT_HELD = 0;
   localparam int SLOT_MIN  = 1;
   localparam int SLOT_MAX  = 2;
   localparam int SLOT_RAW  = 3;

   typedef struct packed {
      logic [TIME_BITS-1:0]  window_start;
      logic [SHIFT_BITS-1:0] pixel_shift;
      logic [PIX_BITS-1:0]   pixel_count;
   } cfg_type;

   typedef struct packed {
      logic [TIME_BITS-1:0]          sample_time;
      logic signed [SAMPLE_BITS-1:0] sample_value;
      logic                          is_final;
   } sample_type;

   typedef struct packed {
      logic [TIME_BITS-1:0]          point_time;
      logic signed [SAMPLE_BITS-1:0] point_value;
      logic signed [SAMPLE_BITS-1:0] range_low;
      logic signed [SAMPLE_BITS-1:0] range_high;
      logic                          end_of_record;
   } point_type;

   typedef struct packed {
      logic [NUM_SLOTS-1:0]             mask;
      point_type [NUM_SLOTS-1:0]        slot;
   } bundle_type;

endpackage

### sv/mmpd_req_if.sv
// Sample channel of the min/max pixel decimator: valid, ready and one sample beat.
// Depends on mmpd_pkg for the field widths.
interface mmpd_req_if import mmpd_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic [TIME_BITS-1:0]          sample_time;
   logic signed [SAMPLE_BITS-1:0] sample_value;
   logic                          is_final;

   modport source (output valid, output sample_time, output sample_value,
                   output is_final, input ready);
   modport sink   (input valid, input sample_time, input sample_value,
                   input is_final, output ready);
endinterface

### sv/mmpd_rsp_if.sv
// Point channel of the min/max pixel decimator: valid, ready and one point beat.
// Depends on mmpd_pkg for the field widths.
interface mmpd_rsp_if import mmpd_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic [TIME_BITS-1:0]          point_time;
   logic signed [SAMPLE_BITS-1:0] point_value;
   logic signed [SAMPLE_BITS-1:0] range_low;
   logic signed [SAMPLE_BITS-1:0] range_high;
   logic                          end_of_record;

   modport source (output valid, output point_time, output point_value,
                   output range_low, output range_high, output end_of_record,
                   input ready);
   modport sink   (input valid, input point_time, input point_value,
                   input range_low, input range_high, input end_of_record,
                   output ready);
endinterface

### sv/mmpd_csr.sv
// Configuration registers of the min/max pixel decimator behind an APB-style port.
// Depends on mmpd_pkg for register codes and the cfg_type bundle.
module mmpd_csr import mmpd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output cfg_type                  cfg
);

   cfg_type    cfg_ff;
   logic       write_en;
   logic [1:0] reg_index;

   assign pready    = 1'b1;
   assign write_en  = psel && penable && pwrite;
   assign reg_index = paddr[CSR_ADDR_BITS-1:2];
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_start <= '0;
         cfg_ff.pixel_shift  <= '0;
         cfg_ff.pixel_count  <= PIX_COUNT_RESET;
      end else if (write_en) begin
         case (reg_index)
            REG_WINDOW_START: cfg_ff.window_start <= pwdata[TIME_BITS-1:0];
            REG_PIXEL_SHIFT:  cfg_ff.pixel_shift  <= pwdata[SHIFT_BITS-1:0];
            REG_PIXEL_COUNT:  cfg_ff.pixel_count  <= pwdata[PIX_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_WINDOW_START: prdata = CSR_DATA_BITS'(cfg_ff.window_start);
         REG_PIXEL_SHIFT:  prdata = CSR_DATA_BITS'(cfg_ff.pixel_shift);
         REG_PIXEL_COUNT:  prdata = CSR_DATA_BITS'(cfg_ff.pixel_count);
         default:          prdata = '0;
      endcase
   end

endmodule

### sv/mmpd_step.sv
// Record state of the min/max pixel decimator and the single-pass logic that
// turns one sample into up to four points. Depends on mmpd_pkg.
module mmpd_step import mmpd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  sample_type sample,
   input  logic       advance,
   output bundle_type bundle
);

   localparam logic [1:0] BUCKET_EMPTY = 2'd0;
   localparam logic [1:0] BUCKET_ONE   = 2'd1;
   localparam logic [1:0] BUCKET_MANY  = 2'd2;

   logic [PIX_BITS-1:0]           current_pixel_ff, current_pixel_in;
   logic [1:0]                    bucket_count_ff, bucket_count_in;
   logic signed [SAMPLE_BITS-1:0] bucket_min_ff, bucket_min_in;
   logic signed [SAMPLE_BITS-1:0] bucket_max_ff, bucket_max_in;
   logic [TIME_BITS-1:0]          single_time_ff, single_time_in;
   logic [TIME_BITS-1:0]          held_time_ff, held_time_in;
   logic signed [SAMPLE_BITS-1:0] held_value_ff, held_value_in;
   logic                          held_valid_ff, held_valid_in;
   logic signed [SAMPLE_BITS-1:0] running_low_ff, running_low_in;
   logic signed [SAMPLE_BITS-1:0] running_high_ff, running_high_in;
   logic                          emitted_any_ff, emitted_any_in;
   logic                          window_done_ff, window_done_in;

   logic [PIX_BITS-1:0]           pix_limit;
   logic                          before_window;
   logic [TIME_BITS-1:0]          pixel_full;
   logic                          past_window;
   logic                          new_pixel;
   logic [TIME_BITS-1:0]          left_edge;
   logic                          bucket_open;
   logic signed [SAMPLE_BITS-1:0] flush_low, flush_high;
   logic signed [SAMPLE_BITS-1:0] post_low, post_high;
   logic                          do_held, do_flush, do_raw, raw_eor, do_clear;

   assign pix_limit     = (cfg.pixel_count > MAX_PIX_CODE) ? MAX_PIX_CODE : cfg.pixel_count;
   assign before_window = sample.sample_time < cfg.window_start;
   assign pixel_full    = (sample.sample_time - cfg.window_start) >> cfg.pixel_shift;
   assign bucket_open   = bucket_count_ff != BUCKET_EMPTY;

   // A sample before the window only reaches here with a pixel open; it joins that pixel.
   assign past_window = before_window ? (current_pixel_ff >= pix_limit)
                                      : (pixel_full >= TIME_BITS'(pix_limit));
   assign new_pixel   = !before_window && (pixel_full != TIME_BITS'(current_pixel_ff));
   assign left_edge   = cfg.window_start + (TIME_BITS'(current_pixel_ff) << cfg.pixel_shift);

   assign flush_low  = (!emitted_any_ff || bucket_min_ff < running_low_ff)
                       ? bucket_min_ff : running_low_ff;
   assign flush_high = (!emitted_any_ff || bucket_max_ff > running_high_ff)
                       ? bucket_max_ff : running_high_ff;
   assign post_low   = bucket_open ? flush_low  : running_low_ff;
   assign post_high  = bucket_open ? flush_high : running_high_ff;

   always_comb begin
      do_held  = 1'b0;
      do_flush = 1'b0;
      do_raw   = 1'b0;
      raw_eor  = 1'b0;
      do_clear = 1'b0;

      current_pixel_in = current_pixel_ff;
      bucket_count_in  = bucket_count_ff;
      bucket_min_in    = bucket_min_ff;
      bucket_max_in    = bucket_max_ff;
      single_time_in   = single_time_ff;
      held_time_in     = held_time_ff;
      held_value_in    = held_value_ff;
      held_valid_in    = held_valid_ff;
      running_low_in   = running_low_ff;
      running_high_in  = running_high_ff;
      emitted_any_in   = emitted_any_ff;
      window_done_in   = window_done_ff;

      if (window_done_ff) begin
         do_clear = sample.is_final;
      end else if (before_window && !bucket_open) begin
         if (sample.is_final) begin
            do_held  = 1'b1;
            do_raw   = 1'b1;
            raw_eor  = 1'b1;
            do_clear = 1'b1;
         end else begin
            held_time_in  = sample.sample_time;
            held_value_in = sample.sample_value;
            held_valid_in = 1'b1;
         end
      end else if (past_window) begin
         do_held         = 1'b1;
         do_flush        = bucket_open;
         do_raw          = 1'b1;
         raw_eor         = sample.is_final;
         do_clear        = sample.is_final;
         window_done_in  = 1'b1;
         bucket_count_in = BUCKET_EMPTY;
      end else begin
         do_held = 1'b1;
         if (sample.is_final) begin
            do_flush = bucket_open;
            do_raw   = 1'b1;
            raw_eor  = 1'b1;
            do_clear = 1'b1;
         end else begin
            do_flush = bucket_open && new_pixel;
            if (bucket_open && !new_pixel) begin
               bucket_count_in = BUCKET_MANY;
               if (sample.sample_value < bucket_min_ff) bucket_min_in = sample.sample_value;
               if (sample.sample_value > bucket_max_ff) bucket_max_in = sample.sample_value;
            end else begin
               bucket_count_in  = BUCKET_ONE;
               bucket_min_in    = sample.sample_value;
               bucket_max_in    = sample.sample_value;
               single_time_in   = sample.sample_time;
               current_pixel_in = pixel_full[PIX_BITS-1:0];
            end
         end
      end

      if (do_held) held_valid_in = 1'b0;
      if (do_flush) begin
         running_low_in  = flush_low;
         running_high_in = flush_high;
         emitted_any_in  = 1'b1;
      end

      // The final sample ends the record: everything returns to the reset state.
      if (do_clear) begin
         current_pixel_in = '0;
         bucket_count_in  = BUCKET_EMPTY;
         bucket_min_in    = '0;
         bucket_max_in    = '0;
         single_time_in   = '0;
         held_time_in     = '0;
         held_value_in    = '0;
         held_valid_in    = 1'b0;
         running_low_in   = '0;
         running_high_in  = '0;
         emitted_any_in   = 1'b0;
         window_done_in   = 1'b0;
      end
   end

   always_comb begin
      bundle.mask[SLOT_HELD] = do_held && held_valid_ff;
      bundle.mask[SLOT_MIN]  = do_flush;
      bundle.mask[SLOT_MAX]  = do_flush && (bucket_count_ff == BUCKET_MANY);
      bundle.mask[SLOT_RAW]  = do_raw;

      bundle.slot[SLOT_HELD] = '{point_time: held_time_ff, point_value: held_value_ff,
                                 range_low: running_low_ff, range_high: running_high_ff,
                                 end_of_record: 1'b0};
      bundle.slot[SLOT_MIN]  = '{point_time: (bucket_count_ff == BUCKET_ONE)
                                             ? single_time_ff : left_edge,
                                 point_value: bucket_min_ff,
                                 range_low: flush_low, range_high: flush_high,
                                 end_of_record: 1'b0};
      bundle.slot[SLOT_MAX]  = '{point_time: left_edge, point_value: bucket_max_ff,
                                 range_low: flush_low, range_high: flush_high,
                                 end_of_record: 1'b0};
      bundle.slot[SLOT_RAW]  = '{point_time: sample.sample_time,
                                 point_value: sample.sample_value,
                                 range_low: post_low, range_high: post_high,
                                 end_of_record: raw_eor};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_pixel_ff <= '0;
         bucket_count_ff  <= BUCKET_EMPTY;
         bucket_min_ff    <= '0;
         bucket_max_ff    <= '0;
         single_time_ff   <= '0;
         held_time_ff     <= '0;
         held_value_ff    <= '0;
         held_valid_ff    <= 1'b0;
         running_low_ff   <= '0;
         running_high_ff  <= '0;
         emitted_any_ff   <= 1'b0;
         window_done_ff   <= 1'b0;
      end else if (advance) begin
         current_pixel_ff <= current_pixel_in;
         bucket_count_ff  <= bucket_count_in;
         bucket_min_ff    <= bucket_min_in;
         bucket_max_ff    <= bucket_max_in;
         single_time_ff   <= single_time_in;
         held_time_ff     <= held_time_in;
         held_value_ff    <= held_value_in;
         held_valid_ff    <= held_valid_in;
         running_low_ff   <= running_low_in;
         running_high_ff  <= running_high_in;
         emitted_any_ff   <= emitted_any_in;
         window_done_ff   <= window_done_in;
      end
   end

   // Once the closing point is out, no pixel or held sample may remain.
   a_done_is_drained: assert property (@(posedge clock) disable iff (reset)
      window_done_ff |-> (bucket_count_ff == BUCKET_EMPTY) && !held_valid_ff)
      else $error("window closed with a pixel or held sample still pending");

   // The range reads zero until the first pixel has closed.
   a_range_zero_until_flush: assert property (@(posedge clock) disable iff (reset)
      !emitted_any_ff |-> (running_low_ff == '0) && (running_high_ff == '0))
      else $error("range moved before any pixel closed");

   // A maximum point is only ever paired with its minimum point.
   a_max_needs_min: assert property (@(posedge clock) disable iff (reset)
      bundle.mask[SLOT_MAX] |-> bundle.mask[SLOT_MIN])
      else $error("maximum point without a minimum point");

endmodule

### sv/minmax_pixel_decimator_top.sv
// Top level of the min/max pixel decimator: sample register, point drain and ports.
// Depends on mmpd_pkg, mmpd_req_if, mmpd_rsp_if, mmpd_csr and mmpd_step.
//
//   Channel   Kind            Direction  Beat
//   req_bus   valid/ready     in         sample_time, sample_value, is_final
//   rsp_bus   valid/ready     out        point_time, point_value, range_low,
//                                        range_high, end_of_record
//   psel...   APB-style       in/out     window_start @0, pixel_shift @4,
//                                        pixel_count @8
//
// A sample waits in the input register, where the single-pass step logic
// turns it into zero to four points and updates the record state in the same cycle.
// A sample that makes no point leaves at once, so such samples stream at one per cycle.
// A sample that makes points waits until the point register is free; its points then
// leave one beat each as rsp_bus takes them; the point register is the rate limit.
// Reset is synchronous and active high; there is no clearing pass.
// Stalls on rsp_bus fill the point register first and then the input register, after
// which req_bus.ready drops.
module minmax_pixel_decimator_top import mmpd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   mmpd_req_if.sink                 req_bus,
   mmpd_rsp_if.source               rsp_bus,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   cfg_type    cfg;
   bundle_type step_out;

   // Input register: one sample waiting for the step logic.
   logic       in_valid_ff;
   sample_type in_item_ff;

   // Point register: the points of one sample, released lowest slot first.
   logic [NUM_SLOTS-1:0] pending_ff, pending_in;
   point_type [NUM_SLOTS-1:0] slot_ff;

   logic                 req_fire;
   logic                 rsp_fire;
   logic [NUM_SLOTS-1:0] take_mask;
   logic [1:0]           take_index;
   logic                 bundle_free;
   logic                 advance;
   logic                 load_bundle;

   mmpd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mmpd_step u_step (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .sample  (in_item_ff),
      .advance (advance),
      .bundle  (step_out)
   );

   // The lowest pending slot goes out first; that keeps the held, min, max, raw order.
   assign take_mask = pending_ff & (~pending_ff + NUM_SLOTS'(1));

   always_comb begin
      if (pending_ff[SLOT_HELD]) begin
         take_index = 2'(SLOT_HELD);
      end else if (pending_ff[SLOT_MIN]) begin
         take_index = 2'(SLOT_MIN);
      end else if (pending_ff[SLOT_MAX]) begin
         take_index = 2'(SLOT_MAX);
      end else begin
         take_index = 2'(SLOT_RAW);
      end
   end

   assign rsp_fire = rsp_bus.valid && rsp_bus.ready;
   assign req_fire = req_bus.valid && req_bus.ready;

   // The point register can take new points when it is empty or its last one leaves now.
   assign bundle_free = (pending_ff == '0) || (rsp_fire && (pending_ff == take_mask));
   assign advance     = in_valid_ff && ((step_out.mask == '0) || bundle_free);
   assign load_bundle = advance && (step_out.mask != '0);

   assign req_bus.ready = !in_valid_ff || advance;

   always_comb begin
      if (load_bundle) begin
         pending_in = step_out.mask;
      end else if (rsp_fire) begin
         pending_in = pending_ff & ~take_mask;
      end else begin
         pending_in = pending_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pending_ff  <= '0;
      end else begin
         if (req_fire) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.sample_time  <= req_bus.sample_time;
         in_item_ff.sample_value <= req_bus.sample_value;
         in_item_ff.is_final     <= req_bus.is_final;
      end
      if (load_bundle) begin
         slot_ff <= step_out.slot;
      end
   end

   assign rsp_bus.valid         = pending_ff != '0;
   assign rsp_bus.point_time    = slot_ff[take_index].point_time;
   assign rsp_bus.point_value   = slot_ff[take_index].point_value;
   assign rsp_bus.range_low     = slot_ff[take_index].range_low;
   assign rsp_bus.range_high    = slot_ff[take_index].range_high;
   assign rsp_bus.end_of_record = slot_ff[take_index].end_of_record;

   // The record's last point is the last point its sample made.
   a_eor_closes_bundle: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_bus.end_of_record |=> (pending_ff == '0) || $past(load_bundle))
      else $error("points of the same sample follow the end of record");

   // New points never overwrite points that have not all gone out.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_bundle |=> $past(pending_ff == '0) || $past(rsp_fire))
      else $error("point register reloaded while points were pending");

endmodule
